// ===== hdl/sc2tb_pkg.sv =====
// Shared types and constants for the scan-code set 2 to terminal byte converter.
// Depends on nothing; the front, queue, back end and top-level files import it.
package sc2tb_pkg;

    // Longest run of terminal bytes one scan byte can cause (ESC ESC [ 5 ~).
    localparam int RUN_MAX = 5;
    localparam int RUN_CW  = $clog2(RUN_MAX + 1);
    localparam int RUN_IW  = $clog2(RUN_MAX);

    // Prefix bytes.
    localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
    localparam logic [7:0] SC_REL_PREFIX = 8'hF0;

    // Modifier key codes.
    localparam logic [7:0] SC_LSHIFT = 8'h12;
    localparam logic [7:0] SC_RSHIFT = 8'h59;
    localparam logic [7:0] SC_CTRL   = 8'h14;
    localparam logic [7:0] SC_ALT    = 8'h11;
    localparam logic [7:0] SC_CAPS   = 8'h58;

    // Extended navigation key codes.
    localparam logic [7:0] SC_UP    = 8'h75;
    localparam logic [7:0] SC_DOWN  = 8'h72;
    localparam logic [7:0] SC_RIGHT = 8'h74;
    localparam logic [7:0] SC_LEFT  = 8'h6B;
    localparam logic [7:0] SC_HOME  = 8'h6C;
    localparam logic [7:0] SC_END   = 8'h69;
    localparam logic [7:0] SC_PGUP  = 8'h7D;
    localparam logic [7:0] SC_PGDN  = 8'h7A;
    localparam logic [7:0] SC_INS   = 8'h70;
    localparam logic [7:0] SC_DEL   = 8'h71;

    localparam logic [7:0] ESC_BYTE = 8'h1B;

    // One classified key event: the terminal bytes it produces, in order.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_CW-1:0]       cnt;
    } t_run;

endpackage

// ===== hdl/sc2tb_ifs.sv =====
// Valid/ready channel interfaces for the scan byte input and terminal byte output.
// Depends on nothing.
interface sc2tb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface sc2tb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hdl/sc2tb_front.sv =====
// Front end: accepts scan bytes, tracks prefix and modifier state, and turns each
// key event into a run of terminal bytes for the queue. Uses sc2tb_pkg.
module sc2tb_front
    import sc2tb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_scan_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_run       o_run
);

    function automatic logic [7:0] plain_char(input logic [7:0] k);
        unique case (k)
            8'h1C: plain_char = "a";   8'h32: plain_char = "b";   8'h21: plain_char = "c";
            8'h23: plain_char = "d";   8'h24: plain_char = "e";   8'h2B: plain_char = "f";
            8'h34: plain_char = "g";   8'h33: plain_char = "h";   8'h43: plain_char = "i";
            8'h3B: plain_char = "j";   8'h42: plain_char = "k";   8'h4B: plain_char = "l";
            8'h3A: plain_char = "m";   8'h31: plain_char = "n";   8'h44: plain_char = "o";
            8'h4D: plain_char = "p";   8'h15: plain_char = "q";   8'h2D: plain_char = "r";
            8'h1B: plain_char = "s";   8'h2C: plain_char = "t";   8'h3C: plain_char = "u";
            8'h2A: plain_char = "v";   8'h1D: plain_char = "w";   8'h22: plain_char = "x";
            8'h35: plain_char = "y";   8'h1A: plain_char = "z";
            8'h16: plain_char = "1";   8'h1E: plain_char = "2";   8'h26: plain_char = "3";
            8'h25: plain_char = "4";   8'h2E: plain_char = "5";   8'h36: plain_char = "6";
            8'h3D: plain_char = "7";   8'h3E: plain_char = "8";   8'h46: plain_char = "9";
            8'h45: plain_char = "0";
            8'h0E: plain_char = 8'h60; 8'h4E: plain_char = 8'h2D; 8'h55: plain_char = 8'h3D;
            8'h54: plain_char = 8'h5B; 8'h5B: plain_char = 8'h5D; 8'h5D: plain_char = 8'h5C;
            8'h4C: plain_char = 8'h3B; 8'h52: plain_char = 8'h27; 8'h41: plain_char = 8'h2C;
            8'h49: plain_char = 8'h2E; 8'h4A: plain_char = 8'h2F;
            8'h29: plain_char = 8'h20; 8'h5A: plain_char = 8'h0A; 8'h66: plain_char = 8'h08;
            8'h0D: plain_char = 8'h09;
            default: plain_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] shifted_char(input logic [7:0] c);
        unique case (c)
            8'h31: shifted_char = 8'h21; 8'h32: shifted_char = 8'h40; 8'h33: shifted_char = 8'h23;
            8'h34: shifted_char = 8'h24; 8'h35: shifted_char = 8'h25; 8'h36: shifted_char = 8'h5E;
            8'h37: shifted_char = 8'h26; 8'h38: shifted_char = 8'h2A; 8'h39: shifted_char = 8'h28;
            8'h30: shifted_char = 8'h29; 8'h2D: shifted_char = 8'h5F; 8'h3D: shifted_char = 8'h2B;
            8'h5B: shifted_char = 8'h7B; 8'h5D: shifted_char = 8'h7D; 8'h5C: shifted_char = 8'h7C;
            8'h3B: shifted_char = 8'h3A; 8'h27: shifted_char = 8'h22; 8'h2C: shifted_char = 8'h3C;
            8'h2E: shifted_char = 8'h3E; 8'h2F: shifted_char = 8'h3F; 8'h60: shifted_char = 8'h7E;
            default: shifted_char = c;
        endcase
    endfunction

    logic r_ext, r_rel, r_lshift, r_rshift, r_caps, r_lctrl, r_rctrl, r_lalt, r_ralt;
    logic n_ext, n_rel, n_lshift, n_rshift, n_caps, n_lctrl, n_rctrl, n_lalt, n_ralt;

    logic       accept;
    logic       mod_hit;
    logic       shift_on, ctrl_on, alt_on;
    logic [7:0] ch;
    logic       is_letter;
    logic [7:0] cased;
    logic [1:0] nav_len;
    logic [7:0] nav_t0;
    t_run       run;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign shift_on  = r_lshift || r_rshift;
    assign ctrl_on   = r_lctrl || r_rctrl;
    assign alt_on    = r_lalt || r_ralt;
    assign ch        = plain_char(i_scan_byte);
    assign is_letter = (ch >= 8'h61) && (ch <= 8'h7A);

    always_comb begin
        if (is_letter) begin
            cased = (shift_on != r_caps) ? (ch - 8'h20) : ch;
        end else if (shift_on) begin
            cased = shifted_char(ch);
        end else begin
            cased = ch;
        end
    end

    // Tail after ESC [ for navigation keys; the two-byte tails all end in a tilde.
    always_comb begin
        nav_len = 2'd0;
        nav_t0  = 8'h00;
        unique case (i_scan_byte)
            SC_UP:    begin nav_len = 2'd1; nav_t0 = "A"; end
            SC_DOWN:  begin nav_len = 2'd1; nav_t0 = "B"; end
            SC_RIGHT: begin nav_len = 2'd1; nav_t0 = "C"; end
            SC_LEFT:  begin nav_len = 2'd1; nav_t0 = "D"; end
            SC_HOME:  begin nav_len = 2'd1; nav_t0 = "H"; end
            SC_END:   begin nav_len = 2'd1; nav_t0 = "F"; end
            SC_PGUP:  begin nav_len = 2'd2; nav_t0 = "5"; end
            SC_PGDN:  begin nav_len = 2'd2; nav_t0 = "6"; end
            SC_INS:   begin nav_len = 2'd2; nav_t0 = "2"; end
            SC_DEL:   begin nav_len = 2'd2; nav_t0 = "3"; end
            default:  ;
        endcase
    end

    always_comb begin
        n_ext    = r_ext;
        n_rel    = r_rel;
        n_lshift = r_lshift;
        n_rshift = r_rshift;
        n_caps   = r_caps;
        n_lctrl  = r_lctrl;
        n_rctrl  = r_rctrl;
        n_lalt   = r_lalt;
        n_ralt   = r_ralt;
        mod_hit  = 1'b0;
        run      = '0;
        if (i_scan_byte == SC_EXT_PREFIX) begin
            n_ext = 1'b1;
        end else if (i_scan_byte == SC_REL_PREFIX) begin
            n_rel = 1'b1;
        end else begin
            n_ext = 1'b0;
            n_rel = 1'b0;
            if (!r_ext) begin
                unique case (i_scan_byte)
                    SC_LSHIFT: begin n_lshift = !r_rel; mod_hit = 1'b1; end
                    SC_RSHIFT: begin n_rshift = !r_rel; mod_hit = 1'b1; end
                    SC_CTRL:   begin n_lctrl  = !r_rel; mod_hit = 1'b1; end
                    SC_ALT:    begin n_lalt   = !r_rel; mod_hit = 1'b1; end
                    SC_CAPS: begin
                        if (!r_rel) begin
                            n_caps  = !r_caps;
                            mod_hit = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end else begin
                unique case (i_scan_byte)
                    SC_CTRL: begin n_rctrl = !r_rel; mod_hit = 1'b1; end
                    SC_ALT:  begin n_ralt  = !r_rel; mod_hit = 1'b1; end
                    default: ;
                endcase
            end
            if (!mod_hit && !r_rel) begin
                if (r_ext) begin
                    if (alt_on) begin
                        run.bytes[run.cnt[RUN_IW-1:0]] = ESC_BYTE;
                        run.cnt = run.cnt + RUN_CW'(1);
                    end
                    if (nav_len != 2'd0) begin
                        run.bytes[run.cnt[RUN_IW-1:0]] = ESC_BYTE;
                        run.cnt = run.cnt + RUN_CW'(1);
                        run.bytes[run.cnt[RUN_IW-1:0]] = 8'h5B;
                        run.cnt = run.cnt + RUN_CW'(1);
                        run.bytes[run.cnt[RUN_IW-1:0]] = nav_t0;
                        run.cnt = run.cnt + RUN_CW'(1);
                        if (nav_len == 2'd2) begin
                            run.bytes[run.cnt[RUN_IW-1:0]] = 8'h7E;
                            run.cnt = run.cnt + RUN_CW'(1);
                        end
                    end
                end else if (ch != 8'h00) begin
                    if (ctrl_on && is_letter) begin
                        // Ctrl with a letter: control code 1 to 26, never ESC first.
                        run.bytes[0] = {3'b000, cased[4:0]};
                        run.cnt      = RUN_CW'(1);
                    end else begin
                        if (alt_on) begin
                            run.bytes[run.cnt[RUN_IW-1:0]] = ESC_BYTE;
                            run.cnt = run.cnt + RUN_CW'(1);
                        end
                        run.bytes[run.cnt[RUN_IW-1:0]] = cased;
                        run.cnt = run.cnt + RUN_CW'(1);
                    end
                end
            end
        end
    end

    assign o_push = accept && (run.cnt != '0);
    assign o_run  = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext    <= 1'b0;
            r_rel    <= 1'b0;
            r_lshift <= 1'b0;
            r_rshift <= 1'b0;
            r_caps   <= 1'b0;
            r_lctrl  <= 1'b0;
            r_rctrl  <= 1'b0;
            r_lalt   <= 1'b0;
            r_ralt   <= 1'b0;
        end else if (accept) begin
            r_ext    <= n_ext;
            r_rel    <= n_rel;
            r_lshift <= n_lshift;
            r_rshift <= n_rshift;
            r_caps   <= n_caps;
            r_lctrl  <= n_lctrl;
            r_rctrl  <= n_rctrl;
            r_lalt   <= n_lalt;
            r_ralt   <= n_ralt;
        end
    end

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_run.cnt <= RUN_CW'(RUN_MAX)))
        else $error("front pushed a run longer than the maximum");

    a_prefix_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((i_scan_byte == SC_EXT_PREFIX) || (i_scan_byte == SC_REL_PREFIX)))
        |-> !o_push)
        else $error("prefix byte produced terminal bytes");

endmodule

// ===== hdl/sc2tb_fifo.sv =====
// Short queue of classified runs between the front and back ends.
// Uses sc2tb_pkg for the run type.
module sc2tb_fifo
    import sc2tb_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_run o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_run          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr, n_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("run pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("run popped from an empty queue");

endmodule

// ===== hdl/sc2tb_back.sv =====
// Back end: walks the run at the head of the queue and sends one terminal byte
// per cycle while ready is high, through the output register. Uses sc2tb_pkg.
module sc2tb_back
    import sc2tb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_run       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [RUN_IW-1:0] r_idx;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_last;
    logic              load;
    logic              at_end;

    assign load    = !r_valid || i_ready;
    assign at_end  = (RUN_CW'(r_idx) + RUN_CW'(1)) == i_head.cnt;
    assign o_pop   = load && !i_empty && at_end;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= at_end ? '0 : r_idx + RUN_IW'(1);
            end
        end
    end

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (RUN_CW'(r_idx) < i_head.cnt))
        else $error("byte index ran past the end of the run");

    a_idx_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == '0))
        else $error("byte index not rewound after a run finished");

endmodule

// ===== hdl/scancode_set2_to_terminal_bytes_unit.sv =====
// Top level of the scan-code set 2 to terminal byte converter.
// Depends on sc2tb_pkg, sc2tb_ifs, sc2tb_front, sc2tb_fifo and sc2tb_back.
//
// Usage. Raw keyboard bytes in scan-code set 2 arrive on i_scan, one byte per
// item, under a valid/ready handshake. Terminal bytes leave on o_term, one per
// item, with last set on the final byte of the run caused by one scan byte.
// Prefix bytes, modifier keys, releases and unmapped keys produce no output,
// except a lone ESC for an unmapped extended key with alt held.
// Data flow. A scan byte is classified in the cycle it is accepted and its run
// is written into a short queue; from there the back end loads it, byte by
// byte, into a registered output stage that drives o_term. The output stage
// sends one byte per cycle while the receiver holds ready high, and a run has
// at most five bytes. The input side accepts one scan byte every cycle while
// the queue has room; scan bytes that produce nothing never enter the queue.
//
//
// Reset (synchronous, active low) clears all prefix and modifier flags, empties
// the queue and drops any byte waiting in the output register. When the
// receiver holds ready low, the output byte holds, the queue fills, and i_scan
// ready falls once QUEUE_DEPTH runs are waiting.
module scancode_set2_to_terminal_bytes_unit
    import sc2tb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sc2tb_in_if.sink     i_scan,
    sc2tb_out_if.source  o_term
);

    // Front to queue.
    logic front_ready;
    logic q_push;
    t_run q_in;

    // Queue to back.
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_run q_head;

    // The front end owns all keyboard state: prefixes, shift, ctrl, alt and
    // caps lock are updated here as each scan byte is accepted.
    sc2tb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_scan.valid),
        .o_ready     (front_ready),
        .i_scan_byte (i_scan.scan_byte),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_run       (q_in)
    );

    assign i_scan.ready = front_ready;

    // The queue lets the front keep taking scan bytes while the back end is
    // still sending a long escape sequence or the receiver is stalled.
    sc2tb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end serialises each run into terminal bytes.
    sc2tb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_term.valid),
        .i_ready (o_term.ready),
        .o_byte  (o_term.out_byte),
        .o_last  (o_term.last)
    );

endmodule
